[rtl/core/mpe_pkg.sv]
package mpe_pkg;

  // Field and register widths
  localparam int unsigned FieldW   = 31;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned DigitW   = 2;
  localparam int unsigned ReduceSteps = ProdW / DigitW;
  localparam int unsigned StepCntW = $clog2(ReduceSteps);

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegModulus   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegEvalPoint = 1'b1;

  // Reset values
  localparam logic [FieldW-1:0] ModulusReset = 31'd998244353;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // take an input word, form both products
    logic step;    // one radix-4 reduction step
    logic commit;  // write back state, emit result on last
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;      // current word ends the polynomial
    logic out_full;  // output register holds a word that is not taken this cycle
  } status_t;

endpackage

[rtl/core/mpe_ctrl.sv]
module mpe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mpe_pkg::status_t status_i,
  output mpe_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StReduce = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [mpe_pkg::StepCntW-1:0]   cnt_q, cnt_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StReduce;
        end
      end
      StReduce: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == mpe_pkg::StepCntW'(mpe_pkg::ReduceSteps - 1)) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        // on a last word, hold off while the previous result still waits
        if (!(status_i.last && status_i.out_full)) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/mpe_datapath.sv]
module mpe_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpe_pkg::FieldW-1:0]   cfg_data_i,
  input  logic [mpe_pkg::FieldW-1:0]   coeff_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mpe_pkg::FieldW-1:0]   result_o,
  input  mpe_pkg::cmd_t                cmd_i,
  output mpe_pkg::status_t             status_o
);

  localparam int unsigned W  = mpe_pkg::FieldW;
  localparam int unsigned PW = mpe_pkg::ProdW;
  localparam int unsigned DW = mpe_pkg::DigitW;

  logic [W-1:0]  modulus_q, eval_point_q;
  logic [W-1:0]  running_sum_q, point_power_q;
  logic [W-1:0]  mod_q;
  logic [PW-1:0] prod_a_q, prod_b_q;
  logic [W-1:0]  rem_a_q, rem_b_q;
  logic          last_q;
  logic          out_valid_q;
  logic [W-1:0]  result_q;
  logic [W-1:0]  mod_eff;

  // One radix-4 step: (4r + d) mod m, with r < m, so at most three m to take off
  function automatic logic [W-1:0] reduce_step(input logic [W-1:0] r,
                                               input logic [DW-1:0] d,
                                               input logic [W-1:0] m);
    logic [W+1:0] v;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    logic [W+1:0] m3;
    logic [W+1:0] res;
    v  = {r, d};
    m1 = (W+2)'(m);
    m2 = m1 << 1;
    m3 = m2 + m1;
    if (v >= m3) begin
      res = v - m3;
    end else if (v >= m2) begin
      res = v - m2;
    end else if (v >= m1) begin
      res = v - m1;
    end else begin
      res = v;
    end
    return res[W-1:0];
  endfunction

  // A modulus of zero acts as one
  assign mod_eff = (modulus_q == '0) ? W'(1) : modulus_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= mpe_pkg::ModulusReset;
      eval_point_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mpe_pkg::RegModulus:   modulus_q    <= cfg_data_i;
        mpe_pkg::RegEvalPoint: eval_point_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      point_power_q <= W'(1);
    end else if (cmd_i.commit) begin
      running_sum_q <= last_q ? '0 : rem_a_q;
      point_power_q <= last_q ? W'(1) : rem_b_q;
    end
  end

  // Products and serial reduction; sum folded into the first product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_a_q <= PW'(coeff_i) * PW'(point_power_q) + PW'(running_sum_q);
      prod_b_q <= PW'(point_power_q) * PW'(eval_point_q);
      rem_a_q  <= '0;
      rem_b_q  <= '0;
      mod_q    <= mod_eff;
      last_q   <= last_i;
    end else if (cmd_i.step) begin
      prod_a_q <= prod_a_q << DW;
      prod_b_q <= prod_b_q << DW;
      rem_a_q  <= reduce_step(rem_a_q, prod_a_q[PW-1 -: DW], mod_q);
      rem_b_q  <= reduce_step(rem_b_q, prod_b_q[PW-1 -: DW], mod_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && last_q) begin
      result_q <= rem_a_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_o          = result_q;
  assign status_o.last     = last_q;
  assign status_o.out_full = out_valid_q && out_stall_i;

endmodule

[rtl/core/modular_polynomial_evaluation.sv]
// Evaluates a polynomial at eval_point modulo modulus. Coefficients arrive one
// word at a time, constant term first; the word with last set returns the value
// and resets the running sum to 0 and the power to 1. Any input or register
// value is reduced fully, and a modulus of 0 behaves as 1. Each coefficient
// goes through these steps before the next word can be taken: the two 31x31
// products are formed, 32 radix-4 reduction steps run over the 64-bit products
// in one reduction unit per product, and the state is written back. A
// finished result waits in its own output register, so the next polynomial
// proceeds until its own last word finds that register still occupied.
// Configuration writes take effect from the next coefficient word onward.
module modular_polynomial_evaluation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpe_pkg::FieldW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mpe_pkg::FieldW-1:0]   coeff_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mpe_pkg::FieldW-1:0]   result_o
);

  mpe_pkg::cmd_t    cmd;
  mpe_pkg::status_t status;

  // Sequencer
  mpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  mpe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .coeff_i     (coeff_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[test/tb_modular_polynomial_evaluation.sv]
`timescale 1ns / 100ps

module tb_modular_polynomial_evaluation;

  typedef logic [mpe_pkg::FieldW-1:0] word_t;

  localparam word_t FieldMax      = {mpe_pkg::FieldW{1'b1}};
  localparam int    NumItems      = 1000;
  localparam int    SettleCycles  = 40;   // covers a coefficient word still in flight
  localparam int    LongHold      = 600;
  localparam int    WatchdogLimit = 5000;

  // Running model of the evaluator plus the queue of sums still owed
  class poly_scoreboard;
    word_t modulus;
    word_t eval_point;
    word_t running_sum;
    word_t point_power;
    word_t sums_due[$];
    int    errors;

    function new();
      modulus     = mpe_pkg::ModulusReset;
      eval_point  = '0;
      running_sum = '0;
      point_power = word_t'(1);
      errors      = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function void write_reg(logic [mpe_pkg::CfgIdxW-1:0] idx, word_t value);
      if (idx == mpe_pkg::RegModulus) begin
        modulus = value;
      end else if (idx == mpe_pkg::RegEvalPoint) begin
        eval_point = value;
      end
    endfunction

    // Accepted coefficient word: fold it into the sum, advance the power
    function void note_word(word_t coeff, logic last);
      logic [63:0] m;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] pow;
      m           = (modulus == '0) ? 64'd1 : 64'(modulus);
      term        = (64'(coeff) * 64'(point_power)) % m;
      acc         = (64'(running_sum) + term) % m;
      pow         = (64'(point_power) * 64'(eval_point)) % m;
      running_sum = acc[mpe_pkg::FieldW-1:0];
      point_power = pow[mpe_pkg::FieldW-1:0];
      if (last) begin
        sums_due.push_back(acc[mpe_pkg::FieldW-1:0]);
        running_sum = '0;
        point_power = word_t'(1);
      end
    endfunction

    // Accepted result word against the oldest sum owed
    function void check_word(logic [mpe_pkg::FieldW-1:0] got);
      word_t want;
      if (sums_due.size() == 0) begin
        report($sformatf("result %0d with no sum owed", got));
      end else begin
        want = sums_due.pop_front();
        if (got !== want) begin
          report($sformatf("result %0d, expected %0d", got, want));
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [mpe_pkg::CfgIdxW-1:0]   cfg_idx_i;
  word_t                         cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  word_t                         coeff_i;
  logic                          last_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  word_t                         result_o;

  poly_scoreboard sb;
  int             words_sent;
  int             idle_cycles;
  int             hold_req;
  bit             calm;

  modular_polynomial_evaluation i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coeff_i     (coeff_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: cycles without any word or register write moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
          $display("tb_modular_polynomial_evaluation: FAIL");
          $finish;
        end
      end
    end
  end

  // Register write; the task returns with the write enable low again
  task automatic write_reg(logic [mpe_pkg::CfgIdxW-1:0] idx, word_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one coefficient word after a random gap, return once taken
  task automatic push_coeff(word_t coeff, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coeff_i    <= coeff;
    last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(coeff, last);
    words_sent++;
  endtask

  // Drain: all sums back, then enough cycles for a word still in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.sums_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic word_t pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FieldMax;
      2:       return sb.modulus;
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return word_t'(1);
      2:       return word_t'(2);
      3:       return FieldMax;
      4:       return mpe_pkg::ModulusReset;
      5:       return word_t'($urandom_range(2, 1000));
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic word_t pick_point();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return word_t'(1);
      2:       return sb.modulus - word_t'(1);
      3:       return FieldMax;
      default: return word_t'($urandom());
    endcase
  endfunction

  // Polynomial of len words; unfinished ones carry their state onward
  task automatic send_poly(int len, bit finish);
    for (int k = 0; k < len; k++) begin
      push_coeff(pick_coeff(), finish && (k == len - 1));
    end
  endtask

  // Result side: random stalls, or one long hold-off when asked
  initial begin
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(result_o);
    end
  end

  // Stimulus
  initial begin
    int phase;
    int plen;
    int count;
    sb          = new();
    words_sent  = 0;
    idle_cycles = 0;
    hold_req    = 0;
    calm        = 1'b0;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = mpe_pkg::RegModulus;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    coeff_i     = '0;
    last_i      = 1'b0;
    out_stall_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: largest coefficient, then a point of zero
    push_coeff(FieldMax, 1'b1);
    push_coeff('0, 1'b0);
    push_coeff(FieldMax, 1'b1);
    settle();

    // Largest modulus, point equal to it (operand not reduced)
    write_reg(mpe_pkg::RegModulus, FieldMax);
    write_reg(mpe_pkg::RegEvalPoint, FieldMax);
    push_coeff(FieldMax - word_t'(1), 1'b0);
    push_coeff(FieldMax, 1'b0);
    push_coeff(word_t'(5), 1'b1);
    settle();

    // Smaller modulus written mid-polynomial: stored state above it
    write_reg(mpe_pkg::RegEvalPoint, word_t'(123456789));
    push_coeff(FieldMax, 1'b0);
    push_coeff(FieldMax - word_t'(1), 1'b0);
    push_coeff(word_t'(1), 1'b0);
    settle();
    write_reg(mpe_pkg::RegModulus, word_t'(1000003));
    push_coeff(word_t'(777), 1'b1);
    settle();

    // Modulus zero and one give zero
    write_reg(mpe_pkg::RegModulus, '0);
    push_coeff(word_t'(12345), 1'b0);
    push_coeff(FieldMax, 1'b1);
    settle();
    write_reg(mpe_pkg::RegModulus, word_t'(1));
    push_coeff(word_t'(9), 1'b0);
    push_coeff(word_t'(3), 1'b1);
    settle();

    // Modulus two, largest point
    write_reg(mpe_pkg::RegModulus, word_t'(2));
    write_reg(mpe_pkg::RegEvalPoint, FieldMax);
    push_coeff(word_t'(1), 1'b0);
    push_coeff(word_t'(1), 1'b0);
    push_coeff(word_t'(1), 1'b1);

    // Random phases; settings are rewritten at random between phases
    phase = 0;
    while (words_sent < NumItems) begin
      settle();
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        write_reg(mpe_pkg::RegModulus, pick_modulus());
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(mpe_pkg::RegEvalPoint, pick_point());
      end
      calm = ($urandom_range(0, 4) == 0);
      plen = $urandom_range(20, 50);
      count = 0;
      if (phase == 3) begin
        // long hold on results while short polynomials keep coming
        calm     = 1'b1;
        hold_req = LongHold;
        while (count < plen) begin
          send_poly(1, 1'b1);
          count++;
        end
      end else begin
        while (count < plen) begin
          n_len: begin
            int len;
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            send_poly(len, 1'b1);
            count += len;
          end
        end
        // sometimes leave a polynomial open across the next settings change
        if ($urandom_range(0, 2) == 0) send_poly($urandom_range(1, 3), 1'b0);
      end
      phase++;
    end

    // Close any open polynomial, then drain
    calm = 1'b0;
    push_coeff(pick_coeff(), 1'b1);
    settle();
    if (sb.errors == 0 && sb.sums_due.size() == 0) begin
      $display("tb_modular_polynomial_evaluation: PASS");
    end else begin
      $display("tb_modular_polynomial_evaluation: FAIL");
    end
    $finish;
  end

endmodule
